[design/rtmp_chp_pkg.sv]
// ----------------------------------------------------------------------------
// rtmp_chp_pkg
// Shared widths, chunk format codes and the message header length table.
// ----------------------------------------------------------------------------
package rtmp_chp_pkg;

  localparam int CSID_W   = 17;
  localparam int F24_W    = 24;
  localparam int HLEN_W   = 5;
  localparam int FIDX_W   = 4;

  localparam logic [F24_W-1:0] MAX24 = 24'hFFFFFF;

  typedef logic [1:0] fmt_t;

  localparam fmt_t FMT_FULL      = 2'd0;
  localparam fmt_t FMT_NO_STREAM = 2'd1;
  localparam fmt_t FMT_DELTA     = 2'd2;
  localparam fmt_t FMT_NONE      = 2'd3;

  // message header bytes per chunk format
  function automatic logic [FIDX_W-1:0] msg_len(input fmt_t fmt);
    logic [FIDX_W-1:0] len;
    case (fmt)
      FMT_FULL:      len = 4'd11;
      FMT_NO_STREAM: len = 4'd7;
      FMT_DELTA:     len = 4'd3;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

[design/rtmp_chp_in_if.sv]
// ----------------------------------------------------------------------------
// rtmp_chp_in_if
// Byte channel into the chunk header parser: valid/ready plus one header byte.
// ----------------------------------------------------------------------------
interface rtmp_chp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/rtmp_chp_out_if.sv]
// ----------------------------------------------------------------------------
// rtmp_chp_out_if
// Result channel of the chunk header parser: valid/ready plus decoded header.
// ----------------------------------------------------------------------------
interface rtmp_chp_out_if;
  import rtmp_chp_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  fmt_t              format_type;
  logic [CSID_W-1:0] chunk_stream_id;
  logic [F24_W-1:0]  timestamp;
  logic [F24_W-1:0]  timestamp_delta;
  logic [F24_W-1:0]  message_length;
  logic [7:0]        message_type;
  logic [31:0]       message_stream_id;
  logic [31:0]       extended_timestamp;
  logic              has_extended;
  logic [HLEN_W-1:0] header_length;

  modport source (
    output valid, output status, output format_type, output chunk_stream_id,
    output timestamp, output timestamp_delta, output message_length,
    output message_type, output message_stream_id, output extended_timestamp,
    output has_extended, output header_length, input ready
  );
  modport sink (
    input valid, input status, input format_type, input chunk_stream_id,
    input timestamp, input timestamp_delta, input message_length,
    input message_type, input message_stream_id, input extended_timestamp,
    input has_extended, input header_length, output ready
  );
endinterface

[design/rtmp_chunk_header_parser.sv]
// ----------------------------------------------------------------------------
// rtmp_chunk_header_parser
// A result is registered and appears in the cycle after the byte that completes the header is accepted.
// Throughput: one byte per cycle; a waiting result stalls the next byte only
// in cycles where the result side is not ready.
// Reset (rst_n low, synchronous): parser idle, parser header fields zero (result fields not reset), no result.
// ----------------------------------------------------------------------------
module rtmp_chunk_header_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  rtmp_chp_in_if.sink            in_if,
  rtmp_chp_out_if.source         out_if
);
  import rtmp_chp_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CSID = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;
  localparam logic [1:0] PH_EXT  = 2'd3;

  logic [1:0]        phase_r,  phase_nxt;
  logic [HLEN_W-1:0] bcnt_r,   bcnt_nxt;
  logic [FIDX_W-1:0] fidx_r,   fidx_nxt;
  fmt_t              fmt_r,    fmt_nxt;
  logic [CSID_W-1:0] csid_r,   csid_nxt;
  logic [F24_W-1:0]  ts_r,     ts_nxt;
  logic [F24_W-1:0]  delta_r,  delta_nxt;
  logic [F24_W-1:0]  len_r,    len_nxt;
  logic [7:0]        type_r,   type_nxt;
  logic [31:0]       stream_r, stream_nxt;
  logic [31:0]       ext_r,    ext_nxt;

  logic              out_valid_r;
  logic              status_r;
  fmt_t              ofmt_r;
  logic [CSID_W-1:0] ocsid_r;
  logic [F24_W-1:0]  ots_r, odelta_r, olen_r;
  logic [7:0]        otype_r;
  logic [31:0]       ostream_r, oext_r;
  logic              ohas_ext_r;
  logic [HLEN_W-1:0] ohlen_r;

  logic       accept;
  logic       done;
  logic       need_ext;
  logic [7:0] b;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    fidx_nxt   = fidx_r;
    fmt_nxt    = fmt_r;
    csid_nxt   = csid_r;
    ts_nxt     = ts_r;
    delta_nxt  = delta_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    stream_nxt = stream_r;
    ext_nxt    = ext_r;
    bcnt_nxt   = bcnt_r + 5'd1;
    done       = 1'b0;
    need_ext   = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        fmt_nxt  = b[7:6];
        csid_nxt = {11'd0, b[5:0]};
        fidx_nxt = '0;
        if (b[5:0] == 6'd0 || b[5:0] == 6'h3F) begin
          phase_nxt = PH_CSID;
        end else if (b[7:6] == FMT_NONE) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_MSG;
        end
      end
      PH_CSID: begin
        if (fidx_r == '0) begin
          csid_nxt = {9'd0, b} + 17'd64;
          if (csid_r == '0) begin
            if (fmt_r == FMT_NONE) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_MSG;
            end
          end else begin
            fidx_nxt = 4'd1;
          end
        end else begin
          csid_nxt = csid_r + {1'b0, b, 8'd0};
          fidx_nxt = '0;
          if (fmt_r == FMT_NONE) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_MSG;
          end
        end
      end
      PH_MSG: begin
        case (fmt_r)
          FMT_FULL: begin
            if (fidx_r < 4'd3) begin
              ts_nxt = {ts_r[15:0], b};
            end else if (fidx_r < 4'd6) begin
              len_nxt = {len_r[15:0], b};
            end else if (fidx_r == 4'd6) begin
              type_nxt = b;
            end else begin
              stream_nxt = {stream_r[23:0], b};
            end
          end
          FMT_NO_STREAM: begin
            if (fidx_r < 4'd3) begin
              delta_nxt = {delta_r[15:0], b};
            end else if (fidx_r < 4'd6) begin
              len_nxt = {len_r[15:0], b};
            end else begin
              type_nxt = b;
            end
          end
          default: begin
            delta_nxt = {delta_r[15:0], b};
          end
        endcase
        fidx_nxt = fidx_r + 4'd1;
        if (fidx_nxt >= msg_len(fmt_r)) begin
          fidx_nxt = '0;
          if (fmt_r == FMT_FULL) begin
            need_ext = (ts_nxt == MAX24);
          end else if (fmt_r == FMT_NO_STREAM || fmt_r == FMT_DELTA) begin
            need_ext = (delta_nxt == MAX24);
          end
          if (need_ext) begin
            phase_nxt = PH_EXT;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        ext_nxt  = {ext_r[23:0], b};
        fidx_nxt = fidx_r + 4'd1;
        if (fidx_nxt >= 4'd4) begin
          done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bcnt_r   <= '0;
      fidx_r   <= '0;
      fmt_r    <= FMT_FULL;
      csid_r   <= '0;
      ts_r     <= '0;
      delta_r  <= '0;
      len_r    <= '0;
      type_r   <= '0;
      stream_r <= '0;
      ext_r    <= '0;
    end else if (accept) begin
      if (done || in_if.last_byte) begin
        phase_r  <= PH_IDLE;
        bcnt_r   <= '0;
        fidx_r   <= '0;
        fmt_r    <= FMT_FULL;
        csid_r   <= '0;
        ts_r     <= '0;
        delta_r  <= '0;
        len_r    <= '0;
        type_r   <= '0;
        stream_r <= '0;
        ext_r    <= '0;
      end else begin
        phase_r  <= phase_nxt;
        bcnt_r   <= bcnt_nxt;
        fidx_r   <= fidx_nxt;
        fmt_r    <= fmt_nxt;
        csid_r   <= csid_nxt;
        ts_r     <= ts_nxt;
        delta_r  <= delta_nxt;
        len_r    <= len_nxt;
        type_r   <= type_nxt;
        stream_r <= stream_nxt;
        ext_r    <= ext_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (done || in_if.last_byte)) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && (done || in_if.last_byte)) begin
      ohlen_r <= bcnt_nxt;
      if (done) begin
        status_r   <= 1'b0;
        ofmt_r     <= fmt_nxt;
        ocsid_r    <= csid_nxt;
        ots_r      <= ts_nxt;
        odelta_r   <= delta_nxt;
        olen_r     <= len_nxt;
        otype_r    <= type_nxt;
        ostream_r  <= stream_nxt;
        oext_r     <= ext_nxt;
        ohas_ext_r <= (phase_r == PH_EXT);
      end else begin
        status_r   <= 1'b1;
        ofmt_r     <= FMT_FULL;
        ocsid_r    <= '0;
        ots_r      <= '0;
        odelta_r   <= '0;
        olen_r     <= '0;
        otype_r    <= '0;
        ostream_r  <= '0;
        oext_r     <= '0;
        ohas_ext_r <= 1'b0;
      end
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.status             = status_r;
  assign out_if.format_type        = ofmt_r;
  assign out_if.chunk_stream_id    = ocsid_r;
  assign out_if.timestamp          = ots_r;
  assign out_if.timestamp_delta    = odelta_r;
  assign out_if.message_length     = olen_r;
  assign out_if.message_type       = otype_r;
  assign out_if.message_stream_id  = ostream_r;
  assign out_if.extended_timestamp = oext_r;
  assign out_if.has_extended       = ohas_ext_r;
  assign out_if.header_length      = ohlen_r;

`ifndef SYNTHESIS
  a_ext_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXT |-> fidx_r < 4'd4)
    else $error("extended timestamp index out of range");

  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r < 5'd18)
    else $error("byte count past longest header");

  a_msg_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MSG |-> fmt_r != FMT_NONE)
    else $error("message header phase with format 3");

  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> !ohas_ext_r && ocsid_r == '0 && ofmt_r == FMT_FULL)
    else $error("truncated result carries header fields");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RTMP chunk header parser. A short table of
// hand-built headers (extremes, each chunk format, truncation) is followed by
// randomly built headers with random content, random truncation and a little
// byte noise. An in-bench parser predicts the random results, and random idle
// bursts on both channels shake the handshakes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtmp_chp_pkg::*;

  localparam int  TOTAL_ITEMS = 1650;
  localparam int  CALM_ITEMS  = 150;
  localparam int  STALL_LIMIT = 1000;
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_TRUNC   = 1'b1;

  typedef struct packed {
    logic              status;
    fmt_t              fmt;
    logic [CSID_W-1:0] csid;
    logic [F24_W-1:0]  ts;
    logic [F24_W-1:0]  delta;
    logic [F24_W-1:0]  len;
    logic [7:0]        mtype;
    logic [31:0]       msid;
    logic [31:0]       ext;
    logic              has_ext;
    logic [HLEN_W-1:0] hlen;
  } hdr_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    bit         typed;
    hdr_t       want;
  } dir_row_t;

  typedef enum logic [2:0] {PS_IDLE, PS_CSID, PS_MSG, PS_EXT} parse_ph_t;

  logic clk = 1'b0;
  logic rst_n;

  rtmp_chp_in_if  in_if ();
  rtmp_chp_out_if out_if ();

  rtmp_chunk_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted parser state
  parse_ph_t         p_ph;
  logic [4:0]        p_cnt;
  logic [3:0]        p_fidx;
  fmt_t              p_fmt;
  logic [CSID_W-1:0] p_csid;
  logic [F24_W-1:0]  p_ts, p_delta, p_len;
  logic [7:0]        p_type;
  logic [31:0]       p_msid, p_ext;

  hdr_t     hdr_exp_q[$];
  dir_row_t dir_tab[$];
  int       mismatches = 0;
  int       n_sent = 0, n_hdrs = 0, n_trunc = 0, n_ext = 0;
  bit       idle_on = 1'b1;
  int       out_hold = 0;
  int       stall_cnt = 0;

  function automatic void clear_parse();
    p_ph = PS_IDLE;
    p_cnt = '0;
    p_fidx = '0;
    p_fmt = FMT_FULL;
    p_csid = '0;
    p_ts = '0;
    p_delta = '0;
    p_len = '0;
    p_type = '0;
    p_msid = '0;
    p_ext = '0;
  endfunction

  function automatic logic [3:0] msg_bytes(input fmt_t f);
    case (f)
      FMT_FULL:      return 4'd11;
      FMT_NO_STREAM: return 4'd7;
      FMT_DELTA:     return 4'd3;
      default:       return 4'd0;
    endcase
  endfunction

  // end of message header: go on to the extended timestamp if flagged
  function automatic bit close_msg();
    p_fidx = '0;
    if ((p_fmt == FMT_FULL && p_ts == MAX24) ||
        ((p_fmt == FMT_NO_STREAM || p_fmt == FMT_DELTA) && p_delta == MAX24)) begin
      p_ph = PS_EXT;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit open_msg();
    p_fidx = '0;
    if (msg_bytes(p_fmt) == 4'd0) return close_msg();
    p_ph = PS_MSG;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic l, output hdr_t r);
    bit done;
    done = 1'b0;
    r = '0;
    p_cnt = p_cnt + 5'd1;
    case (p_ph)
      PS_CSID: begin
        if (p_fidx == 4'd0) begin
          if (p_csid == '0) begin
            p_csid = {9'd0, b} + 17'd64;
            done = open_msg();
          end else begin
            p_csid = {9'd0, b} + 17'd64;
            p_fidx = 4'd1;
          end
        end else begin
          p_csid = p_csid + {1'b0, b, 8'h00};
          done = open_msg();
        end
      end
      PS_MSG: begin
        case (p_fmt)
          FMT_FULL: begin
            if (p_fidx < 4'd3) p_ts = {p_ts[15:0], b};
            else if (p_fidx < 4'd6) p_len = {p_len[15:0], b};
            else if (p_fidx == 4'd6) p_type = b;
            else p_msid = {p_msid[23:0], b};
          end
          FMT_NO_STREAM: begin
            if (p_fidx < 4'd3) p_delta = {p_delta[15:0], b};
            else if (p_fidx < 4'd6) p_len = {p_len[15:0], b};
            else p_type = b;
          end
          default: p_delta = {p_delta[15:0], b};
        endcase
        p_fidx = p_fidx + 4'd1;
        if (p_fidx >= msg_bytes(p_fmt)) done = close_msg();
      end
      PS_EXT: begin
        p_ext = {p_ext[23:0], b};
        p_fidx = p_fidx + 4'd1;
        if (p_fidx >= 4'd4) done = 1'b1;
      end
      default: begin
        p_fmt = b[7:6];
        p_csid = {11'd0, b[5:0]};
        p_fidx = '0;
        if (b[5:0] == 6'd0 || b[5:0] == 6'h3F) p_ph = PS_CSID;
        else done = open_msg();
      end
    endcase
    if (done) begin
      r = '{ST_DONE, p_fmt, p_csid, p_ts, p_delta, p_len, p_type, p_msid, p_ext,
            p_ph == PS_EXT, p_cnt};
      clear_parse();
      return 1'b1;
    end
    if (l) begin
      r.status = ST_TRUNC;
      r.hlen = p_cnt;
      clear_parse();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hdr_t hdr_of(input logic st, input fmt_t f,
                                  input logic [CSID_W-1:0] id, input logic [4:0] n);
    hdr_t r;
    r = '0;
    r.status = st;
    r.fmt = f;
    r.csid = id;
    r.hlen = n;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic l,
                                  input bit typed, input hdr_t want);
    dir_tab.push_back('{b, l, typed, want});
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input hdr_t want);
    hdr_t r;
    bit   got;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.last_byte = l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    got = parse_byte(b, l, r);
    if (got) hdr_exp_q.push_back(typed ? want : r);
    n_sent++;
    @(negedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_if.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(1, 18) - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    hdr_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (hdr_exp_q.size() == 0) begin
        $error("result with no header pending");
        mismatches++;
      end else begin
        want = hdr_exp_q.pop_front();
        n_hdrs++;
        if (want.status == ST_TRUNC) n_trunc++;
        if (want.has_ext) n_ext++;
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("format_type", 32'(want.fmt), 32'(out_if.format_type));
        check_field("chunk_stream_id", 32'(want.csid), 32'(out_if.chunk_stream_id));
        check_field("timestamp", 32'(want.ts), 32'(out_if.timestamp));
        check_field("timestamp_delta", 32'(want.delta), 32'(out_if.timestamp_delta));
        check_field("message_length", 32'(want.len), 32'(out_if.message_length));
        check_field("message_type", 32'(want.mtype), 32'(out_if.message_type));
        check_field("message_stream_id", want.msid, out_if.message_stream_id);
        check_field("extended_timestamp", want.ext, out_if.extended_timestamp);
        check_field("has_extended", 32'(want.has_ext), 32'(out_if.has_extended));
        check_field("header_length", 32'(want.hlen), 32'(out_if.header_length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    hdr_t       big;
    logic [7:0] hb[$];
    fmt_t       f;
    logic [23:0] ts;
    int         cut;
    int         k;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    clear_parse();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // one-byte format 3 header
    add_row(8'hC5, 1'b0, 1'b1, hdr_of(ST_DONE, FMT_NONE, 17'd5, 5'd1));
    // longest header: three-byte id, all ones, extended timestamp, last on final byte
    big = hdr_of(ST_DONE, FMT_FULL, 17'd65599, 5'd18);
    big.ts = MAX24;
    big.len = MAX24;
    big.mtype = 8'hFF;
    big.msid = 32'hFFFF_FFFF;
    big.ext = 32'hFFFF_FFFF;
    big.has_ext = 1'b1;
    add_row(8'h3F, 1'b0, 1'b0, '0);
    for (int i = 0; i < 16; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, big);
    // two-byte id, smallest long id, format 2 all zero
    add_row(8'h80, 1'b0, 1'b0, '0);
    for (int i = 0; i < 3; i++) add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, hdr_of(ST_DONE, FMT_DELTA, 17'd64, 5'd5));
    // buffer ends inside a format 1 message header
    add_row(8'h41, 1'b0, 1'b0, '0);
    add_row(8'h07, 1'b1, 1'b1, hdr_of(ST_TRUNC, FMT_FULL, '0, 5'd2));

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed,
                                   dir_tab[i].want);

    while (n_sent < TOTAL_ITEMS) begin
      if (n_sent > TOTAL_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      hb.delete();
      if ($urandom_range(0, 11) == 0) begin
        // noise burst, closed by last so the next header starts aligned
        repeat ($urandom_range(1, 4)) hb.push_back(8'($urandom));
        cut = hb.size() - 1;
      end else begin
        f = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: begin
            hb.push_back({f, 6'd0});
            hb.push_back(8'($urandom));
          end
          1: begin
            hb.push_back({f, 6'h3F});
            hb.push_back(8'($urandom));
            hb.push_back(8'($urandom));
          end
          default: hb.push_back({f, 6'($urandom_range(1, 62))});
        endcase
        ts = ($urandom_range(0, 3) == 0) ? MAX24 : 24'($urandom);
        if (f != FMT_NONE) begin
          hb.push_back(ts[23:16]);
          hb.push_back(ts[15:8]);
          hb.push_back(ts[7:0]);
        end
        if (f == FMT_FULL || f == FMT_NO_STREAM)
          repeat (4) hb.push_back(8'($urandom));
        if (f == FMT_FULL) repeat (4) hb.push_back(8'($urandom));
        if (f != FMT_NONE && ts == MAX24) repeat (4) hb.push_back(8'($urandom));
        k = $urandom_range(0, 7);
        if (k == 0) cut = $urandom_range(0, hb.size() - 1);
        else if (k == 1) cut = hb.size() - 1;
        else cut = -1;
      end
      foreach (hb[i])
        if (cut < 0 || i <= cut) send_byte(hb[i], i == cut, 1'b0, '0);
    end

    in_if.valid = 1'b0;
    idle_on = 1'b0;
    while (hdr_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d header bytes, checked %0d results", n_sent, n_hdrs);
    $display("  of which %0d truncated and %0d with extended timestamp", n_trunc, n_ext);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rtmp_chp_pkg.sv
design/rtmp_chp_in_if.sv
design/rtmp_chp_out_if.sv
design/rtmp_chunk_header_parser.sv
tb/sv/tb.sv
